// ----- design/ranl_pkg.sv -----
// shared types and constants for the residual add layer norm block
`timescale 1ns / 1ps

package ranl_pkg;

   // field and datapath widths
   localparam int DATA_W  = 16;
   localparam int SUM_W   = 17;
   localparam int TOTAL_W = 23;
   localparam int N_W     = 7;
   localparam int DEV_W   = 24;
   localparam int SQ_W    = 46;
   localparam int ACC_W   = 52;
   localparam int NN_W    = 14;
   localparam int DEN_W   = 27;
   localparam int DVD_W   = 54;
   localparam int RAD_W   = 41;
   localparam int RSTD_W  = 21;
   localparam int P1_W    = 46;
   localparam int PROD_W  = 62;
   localparam int ENTRY_W = SUM_W + 2 * DATA_W;

   // register indexes
   localparam logic [0:0] CSR_ROW_LENGTH = 1'b0;
   localparam logic [0:0] CSR_EPSILON    = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_V_RD,
      S_V_DEV,
      S_V_SQ,
      S_V_ACC,
      S_NN,
      S_DEN,
      S_DIV_VAR,
      S_W_VAR,
      S_VAR,
      S_DIV_RSTD,
      S_W_RSTD,
      S_SQRT,
      S_W_SQRT,
      S_O_RD,
      S_O_DEV,
      S_O_M1,
      S_O_M2,
      S_DIV_Y,
      S_W_Y,
      S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DEV,
      OP_SQ,
      OP_ACC,
      OP_NN,
      OP_DEN,
      OP_DIV_VAR,
      OP_VAR,
      OP_DIV_RSTD,
      OP_SQRT,
      OP_M1,
      OP_M2,
      OP_DIV_Y,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   last;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/residual_add_layer_norm.sv -----
// top level of the residual add layer norm block
//
// Usage: each request transfer carries one row element (x, residual, column
// gain and bias). The block sums x and residual, buffers sum, gain and bias,
// and after row_length transfers normalizes the row and returns one response
// transfer per column in column order, last_of_row set on the final one.
// Loading accepts one element per cycle; req_stall stays low only while loading.
// Once a row is complete: a variance pass reads, deviates, squares and
// accumulates each element, then the divider forms the variance quotient
// and 2^40/v and the root follows; each result then takes one use of the
// bit-serial divider (54 quotient bits per use).
// Results sit in an output register; a stalled response holds its payload and
// the sequencer waits at the next result until the register frees. The last
// result may wait there while loading of the next row proceeds.
// csr index 0 sets row_length (0 acts as 1, above MAX_ROW acts as MAX_ROW),
// index 1 sets epsilon; write only while idle. Reset (synchronous) clears the
// running total and element count, sets row_length 64 and epsilon 1.
`timescale 1ns / 1ps

module residual_add_layer_norm #(
   parameter int MAX_ROW = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ranl_pkg::DATA_W-1:0]  req_x_value,
   input  logic signed [ranl_pkg::DATA_W-1:0]  req_residual_value,
   input  logic signed [ranl_pkg::DATA_W-1:0]  req_gain_value,
   input  logic signed [ranl_pkg::DATA_W-1:0]  req_bias_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ranl_pkg::DATA_W-1:0]  rsp_y_value,
   output logic                                rsp_last_of_row,
   input  logic                                csr_wr_en,
   input  logic [0:0]                          csr_index,
   input  logic [ranl_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int ADDR_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

   logic [ranl_pkg::N_W-1:0]    row_length_ff, row_length_in;
   logic [ranl_pkg::DATA_W-1:0] epsilon_ff, epsilon_in;
   ranl_pkg::dp_cmd_type        cmd;
   ranl_pkg::dp_status_type     status;
   logic [ADDR_W-1:0]           addr;
   logic [ranl_pkg::N_W-1:0]    n;

   // configuration registers
   always_comb begin
      row_length_in = row_length_ff;
      epsilon_in    = epsilon_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ranl_pkg::CSR_ROW_LENGTH: row_length_in = csr_wdata[ranl_pkg::N_W-1:0];
            ranl_pkg::CSR_EPSILON:    epsilon_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ranl_pkg::N_W'(64);
         epsilon_ff    <= ranl_pkg::DATA_W'(1);
      end else begin
         row_length_ff <= row_length_in;
         epsilon_ff    <= epsilon_in;
      end
   end

   ranl_ctrl #(
      .MAX_ROW (MAX_ROW),
      .ADDR_W  (ADDR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .row_length (row_length_ff),
      .status     (status),
      .cmd        (cmd),
      .addr       (addr),
      .n          (n)
   );

   ranl_datapath #(
      .MAX_ROW (MAX_ROW),
      .ADDR_W  (ADDR_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .addr            (addr),
      .n               (n),
      .epsilon         (epsilon_ff),
      .x_value         (req_x_value),
      .residual_value  (req_residual_value),
      .gain_value      (req_gain_value),
      .bias_value      (req_bias_value),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_y_value     (rsp_y_value),
      .rsp_last_of_row (rsp_last_of_row),
      .status          (status)
   );

endmodule

// ----- design/ranl_divider.sv -----
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ranl_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ranl_pkg::DVD_W-1:0]   dividend,
   input  logic [ranl_pkg::DEN_W-1:0]   divisor,
   output logic                         busy,
   output logic [ranl_pkg::DVD_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(ranl_pkg::DVD_W + 1);

   logic [ranl_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [ranl_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [ranl_pkg::DEN_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [ranl_pkg::DEN_W:0]   trial;

   // one shift-subtract step per cycle, quotient bits shift into the dividend word
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, dvd_ff[ranl_pkg::DVD_W-1]};
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(ranl_pkg::DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = ranl_pkg::DEN_W'(trial - {1'b0, div_ff});
            dvd_in = {dvd_ff[ranl_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ranl_pkg::DEN_W-1:0];
            dvd_in = {dvd_ff[ranl_pkg::DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

endmodule

// ----- design/ranl_sqrt.sv -----
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps

module ranl_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ranl_pkg::RAD_W-1:0]    radicand,
   output logic                          busy,
   output logic [ranl_pkg::RSTD_W-1:0]   root
);

   localparam int W     = ranl_pkg::RAD_W + 1;
   localparam int CNT_W = $clog2(ranl_pkg::RSTD_W + 1);

   logic [W-1:0]     a_ff, a_in;
   logic [W-1:0]     res_ff, res_in;
   logic [W-1:0]     bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [W-1:0]     trial;

   // digit-by-digit root: compare against res + bit, then move bit down two places
   always_comb begin
      a_in    = a_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = res_ff + bit_ff;
      if (start) begin
         a_in    = W'(radicand);
         res_in  = '0;
         bit_in  = W'(1) << (ranl_pkg::RAD_W - 1);
         cnt_in  = CNT_W'(ranl_pkg::RSTD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff >= trial) begin
            a_in   = a_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[ranl_pkg::RSTD_W-1:0];

endmodule

// ----- design/ranl_datapath.sv -----
// row buffer, statistics arithmetic and output register
`timescale 1ns / 1ps

module ranl_datapath #(
   parameter int MAX_ROW = 64,
   parameter int ADDR_W  = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ranl_pkg::dp_cmd_type                cmd,
   input  logic [ADDR_W-1:0]                   addr,
   input  logic [ranl_pkg::N_W-1:0]            n,
   input  logic [ranl_pkg::DATA_W-1:0]         epsilon,
   input  logic signed [ranl_pkg::DATA_W-1:0]  x_value,
   input  logic signed [ranl_pkg::DATA_W-1:0]  residual_value,
   input  logic signed [ranl_pkg::DATA_W-1:0]  gain_value,
   input  logic signed [ranl_pkg::DATA_W-1:0]  bias_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [ranl_pkg::DATA_W-1:0]  rsp_y_value,
   output logic                                rsp_last_of_row,
   output ranl_pkg::dp_status_type             status
);

   // row buffer: {sum, gain, bias}
   logic [ranl_pkg::ENTRY_W-1:0] row_mem [MAX_ROW];
   logic [ranl_pkg::ENTRY_W-1:0] rd_ff;

   logic signed [ranl_pkg::SUM_W-1:0]   sum_in, rd_sum;
   logic signed [ranl_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic signed [ranl_pkg::DEV_W-1:0]   dev_ff, dev_in;
   logic [ranl_pkg::SQ_W-1:0]           sq_ff, sq_in;
   logic [ranl_pkg::ACC_W-1:0]          acc_ff, acc_in;
   logic [ranl_pkg::NN_W-1:0]           nn_ff, nn_in;
   logic [ranl_pkg::DEN_W-1:0]          den_ff, den_in;
   logic [ranl_pkg::SUM_W-1:0]          v_ff, v_in;
   logic signed [ranl_pkg::DATA_W-1:0]  gain_ff, gain_in, bias_ff, bias_in;
   logic signed [ranl_pkg::P1_W-1:0]    p1_ff, p1_in;
   logic signed [ranl_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                                neg_ff, neg_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [ranl_pkg::DATA_W-1:0]  y_ff, y_in;
   logic                                last_ff, last_in;

   logic signed [ranl_pkg::N_W:0]       n_s;
   logic signed [ranl_pkg::DEV_W:0]     ns_prod, dev_full;
   logic signed [2*ranl_pkg::DEV_W-1:0] sq_full;
   logic signed [ranl_pkg::RSTD_W:0]    rstd_s;
   logic [ranl_pkg::PROD_W-1:0]         mag;
   logic [ranl_pkg::PROD_W-1:0]         rnd_sum;
   logic [ranl_pkg::DATA_W-1:0]         var_sat;
   logic [ranl_pkg::SUM_W-1:0]          v_sum;
   logic signed [ranl_pkg::SUM_W:0]     q_s;
   logic signed [ranl_pkg::SUM_W+1:0]   y_sum;

   logic                                div_start, sqrt_start;
   logic [ranl_pkg::DVD_W-1:0]          div_dividend, quotient;
   logic [ranl_pkg::DEN_W-1:0]          div_divisor;
   logic                                div_busy, sqrt_busy;
   logic [ranl_pkg::RSTD_W-1:0]         rstd;

   ranl_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   ranl_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (quotient[ranl_pkg::RAD_W-1:0]),
      .busy     (sqrt_busy),
      .root     (rstd)
   );

   assign sum_in = ranl_pkg::SUM_W'(x_value) + ranl_pkg::SUM_W'(residual_value);
   assign rd_sum = rd_ff[ranl_pkg::ENTRY_W-1 -: ranl_pkg::SUM_W];

   // row buffer write on load, registered read every cycle
   always_ff @(posedge clock) begin
      if (cmd.op == ranl_pkg::OP_LOAD) begin
         row_mem[addr] <= {sum_in, gain_value, bias_value};
      end
      rd_ff <= row_mem[addr];
   end

   // arithmetic helpers
   always_comb begin
      n_s      = $signed({1'b0, n});
      ns_prod  = n_s * rd_sum;
      dev_full = ns_prod - (ranl_pkg::DEV_W + 1)'(total_ff);
      sq_full  = dev_ff * dev_ff;
      rstd_s   = $signed({1'b0, rstd});
      mag      = prod_ff[ranl_pkg::PROD_W-1] ? ranl_pkg::PROD_W'(-prod_ff)
                                             : ranl_pkg::PROD_W'(prod_ff);
      rnd_sum  = mag + (ranl_pkg::PROD_W'(n) << 23);
      var_sat  = (quotient[ranl_pkg::DVD_W-1:ranl_pkg::DATA_W] != '0) ? '1
                 : quotient[ranl_pkg::DATA_W-1:0];
      v_sum    = ranl_pkg::SUM_W'(var_sat) + ranl_pkg::SUM_W'(epsilon);
      q_s      = $signed({2'b00, quotient[ranl_pkg::DATA_W-1:0]});
      y_sum    = (neg_ff ? -(ranl_pkg::SUM_W + 2)'(q_s) : (ranl_pkg::SUM_W + 2)'(q_s))
                 + (ranl_pkg::SUM_W + 2)'(bias_ff);
   end

   // divider and root start
   always_comb begin
      div_start    = 1'b0;
      sqrt_start   = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (cmd.op)
         ranl_pkg::OP_DIV_VAR: begin
            div_start    = 1'b1;
            div_dividend = ranl_pkg::DVD_W'(acc_ff) + ranl_pkg::DVD_W'(den_ff >> 1);
            div_divisor  = den_ff;
         end
         ranl_pkg::OP_DIV_RSTD: begin
            div_start    = 1'b1;
            div_dividend = ranl_pkg::DVD_W'(1) << (ranl_pkg::RAD_W - 1);
            div_divisor  = ranl_pkg::DEN_W'(v_ff);
         end
         ranl_pkg::OP_DIV_Y: begin
            div_start    = 1'b1;
            div_dividend = ranl_pkg::DVD_W'(rnd_sum >> 24);
            div_divisor  = ranl_pkg::DEN_W'(n);
         end
         ranl_pkg::OP_SQRT: begin
            sqrt_start = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // per-op register updates
   always_comb begin
      total_in     = total_ff;
      dev_in       = dev_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      nn_in        = nn_ff;
      den_in       = den_ff;
      v_in         = v_ff;
      gain_in      = gain_ff;
      bias_in      = bias_ff;
      p1_in        = p1_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (cmd.op)
         ranl_pkg::OP_LOAD: begin
            total_in = total_ff + ranl_pkg::TOTAL_W'(sum_in);
            acc_in   = '0;
         end
         ranl_pkg::OP_DEV: begin
            dev_in  = dev_full[ranl_pkg::DEV_W-1:0];
            gain_in = rd_ff[2*ranl_pkg::DATA_W-1:ranl_pkg::DATA_W];
            bias_in = rd_ff[ranl_pkg::DATA_W-1:0];
         end
         ranl_pkg::OP_SQ: begin
            sq_in = sq_full[ranl_pkg::SQ_W-1:0];
         end
         ranl_pkg::OP_ACC: begin
            acc_in = acc_ff + ranl_pkg::ACC_W'(sq_ff);
         end
         ranl_pkg::OP_NN: begin
            nn_in = n * n;
         end
         ranl_pkg::OP_DEN: begin
            den_in = (ranl_pkg::DEN_W'(nn_ff) * ranl_pkg::DEN_W'(n)) << 8;
         end
         ranl_pkg::OP_VAR: begin
            v_in = (v_sum == '0) ? ranl_pkg::SUM_W'(1) : v_sum;
         end
         ranl_pkg::OP_M1: begin
            p1_in = dev_ff * rstd_s;
         end
         ranl_pkg::OP_M2: begin
            prod_in = p1_ff * gain_ff;
         end
         ranl_pkg::OP_DIV_Y: begin
            neg_in = prod_ff[ranl_pkg::PROD_W-1];
         end
         ranl_pkg::OP_EMIT: begin
            // saturate the scaled value plus bias to the output range
            if (quotient[ranl_pkg::DVD_W-1:ranl_pkg::DATA_W] != '0) begin
               y_in = neg_ff ? ranl_pkg::DATA_W'(-32768) : ranl_pkg::DATA_W'(32767);
            end else if (y_sum > (ranl_pkg::SUM_W + 2)'(32767)) begin
               y_in = ranl_pkg::DATA_W'(32767);
            end else if (y_sum < -(ranl_pkg::SUM_W + 2)'(32768)) begin
               y_in = ranl_pkg::DATA_W'(-32768);
            end else begin
               y_in = y_sum[ranl_pkg::DATA_W-1:0];
            end
            last_in      = cmd.last;
            rsp_valid_in = 1'b1;
            if (cmd.last) begin
               total_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dev_ff  <= dev_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      nn_ff   <= nn_in;
      den_ff  <= den_in;
      v_ff    <= v_in;
      gain_ff <= gain_in;
      bias_ff <= bias_in;
      p1_ff   <= p1_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      y_ff    <= y_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_y_value      = y_ff;
   assign rsp_last_of_row  = last_ff;
   assign status.div_busy  = div_busy;
   assign status.sqrt_busy = sqrt_busy;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

// ----- design/ranl_ctrl.sv -----
// sequencer for load, variance pass, rstd and output pass
`timescale 1ns / 1ps

module ranl_ctrl #(
   parameter int MAX_ROW = 64,
   parameter int ADDR_W  = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ranl_pkg::N_W-1:0]     row_length,
   input  ranl_pkg::dp_status_type      status,
   output ranl_pkg::dp_cmd_type         cmd,
   output logic [ADDR_W-1:0]            addr,
   output logic [ranl_pkg::N_W-1:0]     n
);

   localparam logic [ranl_pkg::N_W-1:0] MAX_N = ranl_pkg::N_W'(MAX_ROW);

   ranl_pkg::state_type state_ff, state_in;
   logic [ranl_pkg::N_W-1:0] count_ff, count_in;
   logic [ranl_pkg::N_W-1:0] idx_ff, idx_in;
   logic [ranl_pkg::N_W-1:0] n_ff, n_in;
   logic [ranl_pkg::N_W-1:0] eff_len;
   logic                     accept;
   logic                     last_idx;

   // effective row length with out-of-range values folded in
   always_comb begin
      if (row_length == '0) begin
         eff_len = ranl_pkg::N_W'(1);
      end else if (row_length > MAX_N) begin
         eff_len = MAX_N;
      end else begin
         eff_len = row_length;
      end
   end

   assign accept   = req_valid && !req_stall;
   assign last_idx = (idx_ff == n_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ranl_pkg::S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         n_ff     <= n_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      cmd.op   = ranl_pkg::OP_NONE;
      cmd.last = last_idx;
      unique case (state_ff)
         ranl_pkg::S_IDLE: begin
            if (accept) begin
               cmd.op = ranl_pkg::OP_LOAD;
               if (count_ff + 1'b1 >= eff_len) begin
                  n_in     = count_ff + 1'b1;
                  idx_in   = '0;
                  state_in = ranl_pkg::S_V_RD;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ranl_pkg::S_V_RD: state_in = ranl_pkg::S_V_DEV;
         ranl_pkg::S_V_DEV: begin
            cmd.op   = ranl_pkg::OP_DEV;
            state_in = ranl_pkg::S_V_SQ;
         end
         ranl_pkg::S_V_SQ: begin
            cmd.op   = ranl_pkg::OP_SQ;
            state_in = ranl_pkg::S_V_ACC;
         end
         ranl_pkg::S_V_ACC: begin
            cmd.op = ranl_pkg::OP_ACC;
            if (last_idx) begin
               idx_in   = '0;
               state_in = ranl_pkg::S_NN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ranl_pkg::S_V_RD;
            end
         end
         ranl_pkg::S_NN: begin
            cmd.op   = ranl_pkg::OP_NN;
            state_in = ranl_pkg::S_DEN;
         end
         ranl_pkg::S_DEN: begin
            cmd.op   = ranl_pkg::OP_DEN;
            state_in = ranl_pkg::S_DIV_VAR;
         end
         ranl_pkg::S_DIV_VAR: begin
            cmd.op   = ranl_pkg::OP_DIV_VAR;
            state_in = ranl_pkg::S_W_VAR;
         end
         ranl_pkg::S_W_VAR: begin
            if (!status.div_busy) begin
               state_in = ranl_pkg::S_VAR;
            end
         end
         ranl_pkg::S_VAR: begin
            cmd.op   = ranl_pkg::OP_VAR;
            state_in = ranl_pkg::S_DIV_RSTD;
         end
         ranl_pkg::S_DIV_RSTD: begin
            cmd.op   = ranl_pkg::OP_DIV_RSTD;
            state_in = ranl_pkg::S_W_RSTD;
         end
         ranl_pkg::S_W_RSTD: begin
            if (!status.div_busy) begin
               state_in = ranl_pkg::S_SQRT;
            end
         end
         ranl_pkg::S_SQRT: begin
            cmd.op   = ranl_pkg::OP_SQRT;
            state_in = ranl_pkg::S_W_SQRT;
         end
         ranl_pkg::S_W_SQRT: begin
            if (!status.sqrt_busy) begin
               state_in = ranl_pkg::S_O_RD;
            end
         end
         ranl_pkg::S_O_RD: state_in = ranl_pkg::S_O_DEV;
         ranl_pkg::S_O_DEV: begin
            cmd.op   = ranl_pkg::OP_DEV;
            state_in = ranl_pkg::S_O_M1;
         end
         ranl_pkg::S_O_M1: begin
            cmd.op   = ranl_pkg::OP_M1;
            state_in = ranl_pkg::S_O_M2;
         end
         ranl_pkg::S_O_M2: begin
            cmd.op   = ranl_pkg::OP_M2;
            state_in = ranl_pkg::S_DIV_Y;
         end
         ranl_pkg::S_DIV_Y: begin
            cmd.op   = ranl_pkg::OP_DIV_Y;
            state_in = ranl_pkg::S_W_Y;
         end
         ranl_pkg::S_W_Y: begin
            if (!status.div_busy) begin
               state_in = ranl_pkg::S_EMIT;
            end
         end
         ranl_pkg::S_EMIT: begin
            if (status.out_free) begin
               cmd.op = ranl_pkg::OP_EMIT;
               if (last_idx) begin
                  count_in = '0;
                  state_in = ranl_pkg::S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ranl_pkg::S_O_RD;
               end
            end
         end
         default: state_in = ranl_pkg::S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ranl_pkg::S_IDLE);
   assign addr      = (state_ff == ranl_pkg::S_IDLE) ? count_ff[ADDR_W-1:0]
                                                     : idx_ff[ADDR_W-1:0];
   assign n         = n_ff;

   // a result goes out only into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == ranl_pkg::OP_EMIT |-> status.out_free)
      else $error("emit while output register is occupied");

   // the divider is never restarted while it runs
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == ranl_pkg::OP_DIV_VAR || cmd.op == ranl_pkg::OP_DIV_RSTD ||
       cmd.op == ranl_pkg::OP_DIV_Y) |-> !status.div_busy)
      else $error("divider started while busy");

   // a row in progress has a length within the buffer
   a_row_len: assert property (@(posedge clock) disable iff (reset)
      state_ff != ranl_pkg::S_IDLE |-> (n_ff != '0 && n_ff <= MAX_N))
      else $error("row length out of range");

   // the last result of a row hands control back to loading
   a_row_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == ranl_pkg::OP_EMIT && cmd.last) |=>
         (state_ff == ranl_pkg::S_IDLE && count_ff == '0))
      else $error("row did not close after its last result");

endmodule

// ----- tb/tb_residual_add_layer_norm.sv -----
// self-checking testbench for the residual add layer norm block
`timescale 1ns / 1ps

module tb_residual_add_layer_norm;

   localparam int ROW_MAX     = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 300;
   localparam int HOLD_CYCLES = 2000;

   typedef struct {
      logic signed [ranl_pkg::DATA_W-1:0] x;
      logic signed [ranl_pkg::DATA_W-1:0] r;
      logic signed [ranl_pkg::DATA_W-1:0] g;
      logic signed [ranl_pkg::DATA_W-1:0] b;
   } elem_type;

   typedef struct {
      logic signed [ranl_pkg::DATA_W-1:0] y;
      logic                               last;
   } norm_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [ranl_pkg::DATA_W-1:0] req_x_value = '0;
   logic signed [ranl_pkg::DATA_W-1:0] req_residual_value = '0;
   logic signed [ranl_pkg::DATA_W-1:0] req_gain_value = '0;
   logic signed [ranl_pkg::DATA_W-1:0] req_bias_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ranl_pkg::DATA_W-1:0] rsp_y_value;
   logic rsp_last_of_row;
   logic csr_wr_en = 1'b0;
   logic [0:0] csr_index = ranl_pkg::CSR_ROW_LENGTH;
   logic [ranl_pkg::DATA_W-1:0] csr_wdata = '0;

   // stimulus and scoreboard state
   elem_type        pending_elems[$];
   norm_result_type expected_norm_q[$];
   int  pushed_cnt = 0;
   int  accepted_cnt = 0;
   int  checked_cnt = 0;
   int  rows_closed = 0;
   int  error_cnt = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   logic pressure_req = 1'b0;
   logic pressure_done = 1'b0;
   int  press_cnt = 0;
   int  cycle_cnt = 0;

   // predictor copy of block state and registers
   logic signed [ranl_pkg::SUM_W-1:0]   sum_mem[ROW_MAX];
   logic signed [ranl_pkg::DATA_W-1:0]  gain_mem[ROW_MAX];
   logic signed [ranl_pkg::DATA_W-1:0]  bias_mem[ROW_MAX];
   logic signed [ranl_pkg::TOTAL_W-1:0] run_total = '0;
   int                                  elem_count = 0;
   logic [ranl_pkg::N_W-1:0]            len_reg = 7'd64;
   logic [ranl_pkg::DATA_W-1:0]         eps_reg = 16'd1;

   residual_add_layer_norm dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_x_value(req_x_value), .req_residual_value(req_residual_value),
      .req_gain_value(req_gain_value), .req_bias_value(req_bias_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_y_value(rsp_y_value), .rsp_last_of_row(rsp_last_of_row),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // bitwise integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned a);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > a) bitv >>= 2;
      while (bitv != 0) begin
         if (a >= res + bitv) begin
            a -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // buffer one element; on row close, queue the normalized row
   task automatic add_norm_element(elem_type e);
      int idx;
      int n;
      int eff;
      longint total;
      longint dev;
      longint prod;
      longint signed yv;
      longint unsigned sq;
      longint unsigned den;
      longint unsigned var_q;
      longint unsigned v;
      longint unsigned rstd;
      longint unsigned mag;
      longint unsigned q;
      norm_result_type res;
      idx = (elem_count >= ROW_MAX) ? ROW_MAX - 1 : elem_count;
      sum_mem[idx]  = ranl_pkg::SUM_W'(e.x) + ranl_pkg::SUM_W'(e.r);
      gain_mem[idx] = e.g;
      bias_mem[idx] = e.b;
      run_total     = run_total + ranl_pkg::TOTAL_W'(sum_mem[idx]);
      n = idx + 1;
      eff = (len_reg == 0) ? 1 : (len_reg > ROW_MAX) ? ROW_MAX : int'(len_reg);
      if (n < eff) begin
         elem_count = n;
         return;
      end
      total = run_total;
      sq = 0;
      for (int i = 0; i < n; i++) begin
         dev = longint'(n) * longint'(sum_mem[i]) - total;
         mag = (dev < 0) ? -dev : dev;
         sq += mag * mag;
      end
      den = longint'(n) * n * n * 256;
      var_q = (sq + den / 2) / den;
      if (var_q > 65535) var_q = 65535;
      v = var_q + eps_reg;
      if (v == 0) v = 1;
      rstd = int_sqrt((64'd1 << 40) / v);
      den = longint'(n) << 24;
      for (int i = 0; i < n; i++) begin
         dev  = longint'(n) * longint'(sum_mem[i]) - total;
         prod = dev * longint'(rstd) * longint'(gain_mem[i]);
         mag  = (prod < 0) ? -prod : prod;
         q    = (mag + den / 2) / den;
         yv   = (prod < 0) ? -longint'(q) : longint'(q);
         yv  += longint'(bias_mem[i]);
         if (yv > 32767) yv = 32767;
         if (yv < -32768) yv = -32768;
         res.y = yv[ranl_pkg::DATA_W-1:0];
         res.last = (i + 1 == n);
         expected_norm_q.push_back(res);
      end
      rows_closed++;
      run_total = '0;
      elem_count = 0;
   endtask

   // request driver: predicts on each accepted transfer, then offers the next element
   always @(posedge clock) begin
      elem_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            e.x = req_x_value;
            e.r = req_residual_value;
            e.g = req_gain_value;
            e.b = req_bias_value;
            add_norm_element(e);
            accepted_cnt++;
         end
         if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            e = pending_elems.pop_front();
            req_x_value        <= e.x;
            req_residual_value <= e.r;
            req_gain_value     <= e.g;
            req_bias_value     <= e.b;
            req_valid          <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (pressure_req && !pressure_done) begin
         if (press_cnt == HOLD_CYCLES) pressure_done <= 1'b1;
         else press_cnt <= press_cnt + 1;
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      norm_result_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (pressure_req && !pressure_done) || ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_norm_q.size() == 0) begin
               $error("unexpected transfer: y_value %0d last_of_row %0b",
                      rsp_y_value, rsp_last_of_row);
               error_cnt++;
            end else begin
               exp_r = expected_norm_q.pop_front();
               checked_cnt++;
               if (rsp_y_value !== exp_r.y) begin
                  $error("y_value expected %0d actual %0d", exp_r.y, rsp_y_value);
                  error_cnt++;
               end
               if (rsp_last_of_row !== exp_r.last) begin
                  $error("last_of_row expected %0b actual %0b", exp_r.last, rsp_last_of_row);
                  error_cnt++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_elem(int x, int r, int g, int b);
      elem_type e;
      e.x = x[ranl_pkg::DATA_W-1:0];
      e.r = r[ranl_pkg::DATA_W-1:0];
      e.g = g[ranl_pkg::DATA_W-1:0];
      e.b = b[ranl_pkg::DATA_W-1:0];
      pending_elems.push_back(e);
      pushed_cnt++;
   endtask

   // half full-range values, half small values so variance stays unsaturated
   function automatic int rand_field();
      if ($urandom_range(1) == 0) return int'($urandom);
      return int'($urandom_range(2047)) - 1024;
   endfunction

   task automatic push_random(int count);
      repeat (count) push_elem(rand_field(), rand_field(), rand_field(), rand_field());
   endtask

   task automatic write_csr(logic [0:0] idx, logic [ranl_pkg::DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == ranl_pkg::CSR_ROW_LENGTH) len_reg = data[ranl_pkg::N_W-1:0];
      else eps_reg = data;
   endtask

   task automatic wait_drained();
      while (!(accepted_cnt == pushed_cnt && expected_norm_q.size() == 0))
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(int len, int eps, int count, int s_idle, int r_idle);
      write_csr(ranl_pkg::CSR_ROW_LENGTH, ranl_pkg::DATA_W'(len));
      write_csr(ranl_pkg::CSR_EPSILON, ranl_pkg::DATA_W'(eps));
      send_idle_pct = s_idle;
      stall_pct = r_idle;
      push_random(count);
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // row length zero acts as one, zero epsilon
      write_csr(ranl_pkg::CSR_ROW_LENGTH, 16'd0);
      write_csr(ranl_pkg::CSR_EPSILON, 16'd0);
      push_elem(0, 0, 32767, 0);
      push_elem(32767, 32767, -32768, 32767);
      push_elem(-32768, -32768, 32767, -32768);
      wait_drained();

      // zero variance with zero epsilon, then field extremes
      write_csr(ranl_pkg::CSR_ROW_LENGTH, 16'd4);
      repeat (4) push_elem(5, -5, 32767, 0);
      push_elem(32767, 32767, 32767, 32767);
      push_elem(-32768, -32768, -32768, -32768);
      push_elem(32767, -32768, 32767, -32768);
      push_elem(0, 0, 1, 0);
      wait_drained();

      // largest epsilon
      write_csr(ranl_pkg::CSR_EPSILON, 16'hFFFF);
      push_random(4);
      wait_drained();

      // row length lowered while a row is part loaded
      write_csr(ranl_pkg::CSR_ROW_LENGTH, 16'd8);
      write_csr(ranl_pkg::CSR_EPSILON, 16'd1);
      push_random(5);
      wait_drained();
      write_csr(ranl_pkg::CSR_ROW_LENGTH, 16'd3);
      push_random(1);
      wait_drained();

      // row length above the maximum acts as the maximum, then random row lengths
      run_phase(127, int'($urandom_range(65535)), 64, 0, 0);
      run_phase(int'($urandom_range(12, 1)), 1, 14, 0, 0);
      run_phase(int'($urandom_range(12, 1)), int'($urandom_range(255)), 14, 60, 0);
      run_phase(int'($urandom_range(12, 1)), int'($urandom_range(65535)), 14, 0, 60);
      run_phase(int'($urandom_range(12, 1)), 0, 14, 31, 31);

      // long receiver hold-off while requests keep coming
      write_csr(ranl_pkg::CSR_ROW_LENGTH, 16'd4);
      write_csr(ranl_pkg::CSR_EPSILON, 16'd64);
      send_idle_pct = 0;
      stall_pct = 0;
      pressure_req <= 1'b1;
      push_random(12);
      wait_drained();

      if (expected_norm_q.size() != 0) begin
         $error("%0d expected results never arrived", expected_norm_q.size());
         error_cnt++;
      end
      $display("covered %0d element transfers, %0d rows normalized, %0d results checked",
               accepted_cnt, rows_closed, checked_cnt);
      $display("%0d mismatches over %0d cycles", error_cnt, cycle_cnt);
      if (error_cnt == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/ranl_pkg.sv
design/ranl_divider.sv
design/ranl_sqrt.sv
design/ranl_datapath.sv
design/ranl_ctrl.sv
design/residual_add_layer_norm.sv
tb/tb_residual_add_layer_norm.sv
